// ===== design/trilinear_grid_interpolator_assert.svh =====
// Assertion macros for the checker file of the trilinear grid interpolator.
`ifndef TRILINEAR_GRID_INTERPOLATOR_ASSERT_SVH
`define TRILINEAR_GRID_INTERPOLATOR_ASSERT_SVH

// Property checked at every rising clock edge, masked while reset is high.
`define TGI_ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every rising clock edge, reset included.
`define TGI_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/tgi_pkg.sv =====
// Package: widths, request codes and blend arithmetic for the trilinear grid interpolator.
package tgi_pkg;

   localparam int GRID_POINTS_DEF = 16;

   localparam int VALUE_W    = 24;
   localparam int COORD_W    = 17;
   localparam int ENTRY_W    = 4;
   localparam int FRAC_W     = 17;
   localparam int FRAC_SHIFT = 16;
   localparam int DIFF_W     = VALUE_W + 1;
   localparam int PROD_W     = DIFF_W + FRAC_W + 1;
   localparam int HI_W       = PROD_W - FRAC_SHIFT;
   localparam int NUM_BANKS  = 8;
   localparam int BANK_W     = 3;

   localparam logic [FRAC_W-1:0] ONE_Q16 = FRAC_W'(65536);

   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic [FRAC_W-1:0]         frac_type;

   typedef enum logic {
      REQ_WRITE = 1'b0,
      REQ_QUERY = 1'b1
   } req_kind_type;

   // (b - a) * f, full precision
   function automatic prod_type blend_prod(input value_type a, input value_type b,
                                           input frac_type f);
      logic signed [DIFF_W-1:0] d;
      logic signed [FRAC_W:0]   fs;
      d  = DIFF_W'(b) - DIFF_W'(a);
      fs = $signed({1'b0, f});
      return d * fs;
   endfunction

   // a + floor(p / 2^16); result stays between the two blended samples
   function automatic value_type blend_sum(input value_type a, input prod_type p);
      logic signed [HI_W-1:0] hi;
      logic signed [HI_W-1:0] sum;
      hi  = p[PROD_W-1:FRAC_SHIFT];
      sum = hi + HI_W'(a);
      return sum[VALUE_W-1:0];
   endfunction

endpackage

// ===== design/trilinear_grid_interpolator.sv =====
// Top level: banked grid store and pipelined trilinear interpolation.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  req     | in        | req_valid/req_ready  | req_type, req_coord_x/y/z, req_entry_x/y/z,
//          |           |                      | req_entry_value
//  rsp     | out       | rsp_valid/rsp_ready  | rsp_interp_value
//
//  One item per cycle unless a result waits at rsp; a query's result passes the memory read,
//  x, y, z blend and output registers before rsp_valid rises.
//  The eight corners come from eight memory banks split by index parity, so every
//  corner has a bank of its own and all are read in the accept cycle.
//  Writes land in the accept cycle too, so a later query always sees them.
//  Reset (synchronous) clears the pipeline valids only; grid contents are kept.
//  The pipeline moves as a whole: it stalls only while a result waits at rsp.
module trilinear_grid_interpolator #(
   parameter int GRID_POINTS = tgi_pkg::GRID_POINTS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_type,
   input  logic        [tgi_pkg::COORD_W-1:0]  req_coord_x,
   input  logic        [tgi_pkg::COORD_W-1:0]  req_coord_y,
   input  logic        [tgi_pkg::COORD_W-1:0]  req_coord_z,
   input  logic        [tgi_pkg::ENTRY_W-1:0]  req_entry_x,
   input  logic        [tgi_pkg::ENTRY_W-1:0]  req_entry_y,
   input  logic        [tgi_pkg::ENTRY_W-1:0]  req_entry_z,
   input  logic signed [tgi_pkg::VALUE_W-1:0]  req_entry_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [tgi_pkg::VALUE_W-1:0]  rsp_interp_value
);

   // cell index width, product width of coord * (N-1)
   localparam int CELL_W     = $clog2(GRID_POINTS);
   localparam int MUL_W      = tgi_pkg::COORD_W + CELL_W;
   localparam int HALF_PTS   = (GRID_POINTS + 1) / 2;
   localparam int HALF_W     = (HALF_PTS > 1) ? $clog2(HALF_PTS) : 1;
   localparam int ADDR_W     = 3 * HALF_W;
   localparam int BANK_DEPTH = 1 << ADDR_W;

   typedef logic [CELL_W-1:0] cell_type;
   typedef logic [HALF_W-1:0] half_type;

   // ---------------------------------------------------------------- handshake
   logic adv;
   logic accept;
   logic query_acc;
   logic write_acc;

   logic out_valid_ff;
   tgi_pkg::value_type out_value_ff;

   assign adv       = !out_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign accept    = req_valid && adv;
   assign query_acc = accept && (req_type == tgi_pkg::REQ_QUERY);

   assign rsp_valid        = out_valid_ff;
   assign rsp_interp_value = out_value_ff;

   // ---------------------------------------------------------------- axis split
   // s = c * (N-1); cell = s >> 16, frac = low 16 bits; top edge clamps to N-2, 1.0
   logic [tgi_pkg::COORD_W-1:0] coord    [3];
   cell_type                    cell_idx [3];
   tgi_pkg::frac_type           frac     [3];

   assign coord[0] = req_coord_x;
   assign coord[1] = req_coord_y;
   assign coord[2] = req_coord_z;

   always_comb begin
      logic [MUL_W-1:0]  s;
      logic [CELL_W:0]   k;
      for (int a = 0; a < 3; a++) begin
         s = MUL_W'(coord[a]) * MUL_W'(GRID_POINTS - 1);
         k = s[MUL_W-1:tgi_pkg::FRAC_SHIFT];
         if (k >= (CELL_W + 1)'(GRID_POINTS - 1)) begin
            cell_idx[a] = CELL_W'(GRID_POINTS - 2);
            frac[a]     = tgi_pkg::ONE_Q16;
         end else begin
            cell_idx[a] = CELL_W'(k);
            frac[a]     = {1'b0, s[tgi_pkg::FRAC_SHIFT-1:0]};
         end
      end
   end

   // ---------------------------------------------------------------- bank addresses
   // Along an axis, the bank of parity p holds either cell or cell+1, whichever
   // has that parity; its row inside the bank is that index halved.
   half_type          half_sel [3][2];
   logic [ADDR_W-1:0] rd_addr  [tgi_pkg::NUM_BANKS];

   always_comb begin
      cell_type sum;
      for (int a = 0; a < 3; a++) begin
         for (int p = 0; p < 2; p++) begin
            sum            = cell_idx[a] + CELL_W'(cell_idx[a][0] ^ p[0]);
            half_sel[a][p] = HALF_W'(sum >> 1);
         end
      end
      for (int b = 0; b < tgi_pkg::NUM_BANKS; b++) begin
         rd_addr[b] = {half_sel[0][b / 4], half_sel[1][(b / 2) % 2], half_sel[2][b % 2]};
      end
   end

   // write target: bank by index parity, row by halved index; out-of-grid writes dropped
   logic                          wr_in_grid;
   logic [tgi_pkg::BANK_W-1:0]    wr_bank;
   logic [ADDR_W-1:0]             wr_addr;

   assign wr_in_grid = (32'(req_entry_x) < GRID_POINTS) &&
                       (32'(req_entry_y) < GRID_POINTS) &&
                       (32'(req_entry_z) < GRID_POINTS);
   assign write_acc  = accept && (req_type == tgi_pkg::REQ_WRITE) && wr_in_grid;
   assign wr_bank    = {req_entry_x[0], req_entry_y[0], req_entry_z[0]};
   assign wr_addr    = {HALF_W'(req_entry_x >> 1), HALF_W'(req_entry_y >> 1),
                        HALF_W'(req_entry_z >> 1)};

   // ---------------------------------------------------------------- grid banks
   // Stage 1 output: corner data registered by the memory read.
   tgi_pkg::value_type bank_rd_ff [tgi_pkg::NUM_BANKS];

   for (genvar b = 0; b < tgi_pkg::NUM_BANKS; b++) begin : g_bank
      tgi_pkg::value_type grid_mem [BANK_DEPTH];

      always_ff @(posedge clock) begin
         if (write_acc && (wr_bank == tgi_pkg::BANK_W'(b))) begin
            grid_mem[wr_addr] <= req_entry_value;
         end
         if (adv) begin
            bank_rd_ff[b] <= grid_mem[rd_addr[b]];
         end
      end
   end

   // ---------------------------------------------------------------- stage 1 side data
   logic               v1_ff, v2_ff, v3_ff, v4_ff;
   logic [2:0]         par1_ff;
   tgi_pkg::frac_type  fx1_ff, fy1_ff, fz1_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         par1_ff <= {cell_idx[0][0], cell_idx[1][0], cell_idx[2][0]};
         fx1_ff  <= frac[0];
         fy1_ff  <= frac[1];
         fz1_ff  <= frac[2];
      end
   end

   // ---------------------------------------------------------------- stage 2: x blends
   // blend j covers (dy, dz) = (j/2, j%2); a is the x0 corner, b the x0+1 corner
   tgi_pkg::value_type corner_a [4];
   tgi_pkg::value_type corner_b [4];
   tgi_pkg::prod_type  px_in    [4];

   always_comb begin
      logic [2:0] ia;
      logic [2:0] ib;
      for (int j = 0; j < 4; j++) begin
         ia          = par1_ff ^ {1'b0, 2'(j)};
         ib          = par1_ff ^ {1'b1, 2'(j)};
         corner_a[j] = bank_rd_ff[ia];
         corner_b[j] = bank_rd_ff[ib];
         px_in[j]    = tgi_pkg::blend_prod(corner_a[j], corner_b[j], fx1_ff);
      end
   end

   tgi_pkg::prod_type  px2_ff [4];
   tgi_pkg::value_type ax2_ff [4];
   tgi_pkg::frac_type  fy2_ff, fz2_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         px2_ff <= px_in;
         ax2_ff <= corner_a;
         fy2_ff <= fy1_ff;
         fz2_ff <= fz1_ff;
      end
   end

   // ---------------------------------------------------------------- stage 3: y blends
   tgi_pkg::value_type cx [4];
   tgi_pkg::prod_type  py_in [2];

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         cx[j] = tgi_pkg::blend_sum(ax2_ff[j], px2_ff[j]);
      end
      // c0 = blend(c00, c10), c1 = blend(c01, c11)
      for (int k = 0; k < 2; k++) begin
         py_in[k] = tgi_pkg::blend_prod(cx[k], cx[k + 2], fy2_ff);
      end
   end

   tgi_pkg::prod_type  py3_ff [2];
   tgi_pkg::value_type ay3_ff [2];
   tgi_pkg::frac_type  fz3_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         py3_ff    <= py_in;
         ay3_ff[0] <= cx[0];
         ay3_ff[1] <= cx[1];
         fz3_ff    <= fz2_ff;
      end
   end

   // ---------------------------------------------------------------- stage 4: z blend
   tgi_pkg::value_type cy0, cy1;
   tgi_pkg::prod_type  pz4_ff;
   tgi_pkg::value_type az4_ff;

   assign cy0 = tgi_pkg::blend_sum(ay3_ff[0], py3_ff[0]);
   assign cy1 = tgi_pkg::blend_sum(ay3_ff[1], py3_ff[1]);

   always_ff @(posedge clock) begin
      if (adv) begin
         pz4_ff <= tgi_pkg::blend_prod(cy0, cy1, fz3_ff);
         az4_ff <= cy0;
      end
   end

   // ---------------------------------------------------------------- output register
   always_ff @(posedge clock) begin
      if (adv) begin
         out_value_ff <= tgi_pkg::blend_sum(az4_ff, pz4_ff);
      end
   end

   // pipeline valids; only queries enter, writes leave no trace here
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff        <= query_acc;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         out_valid_ff <= v4_ff;
      end
   end

endmodule

// ===== design/tgi_checker.sv =====
// Port-level checker for the trilinear grid interpolator, bound to the top level.
`include "trilinear_grid_interpolator_assert.svh"

module tgi_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [tgi_pkg::VALUE_W-1:0] rsp_interp_value
);

   // a stalled result stays offered
   `TGI_ASSERT_RST(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "rsp_valid dropped before transfer")

   // a stalled result keeps its value
   `TGI_ASSERT_RST(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_interp_value), "rsp payload changed while stalled")

   // nothing is offered right after a reset edge
   `TGI_ASSERT_ALWAYS(a_rsp_reset, clock, reset |=> !rsp_valid, "rsp_valid high after reset")

   // input side never blocks while the output register is empty or drained
   `TGI_ASSERT_RST(a_req_open, clock, reset, !rsp_valid || rsp_ready |-> req_ready, "req_ready low with free output")

endmodule

bind trilinear_grid_interpolator tgi_checker u_tgi_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_interp_value (rsp_interp_value)
);
